// ===== rtl/core/g2g_pkg.sv =====
// Package: shared widths, CORDIC constants and register codes for the go-to-goal core.
`timescale 1ns / 1ps
`default_nettype none
package g2g_pkg;

	localparam int DATA_WIDTH    = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int NSTG  = (CORDIC_STAGES < 8) ? 8 : ((CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES);
	localparam int GUARD = (DATA_WIDTH - 8 < 4) ? 4 : ((DATA_WIDTH - 8 > 24) ? 24 : DATA_WIDTH - 8);
	// vectoring datapath width: 17 bit error, guard bits, growth
	localparam int VW = 17 + GUARD + 3;
	// angle width for Q30 values up to a few times 2*pi
	localparam int AW = 36;

	localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [AW-1:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [20:0]   K_Q20       = 21'sd636751;
	localparam logic signed [32:0]   K_Q30       = 33'sd652032874;

	typedef enum logic [1:0] {
		REG_GOAL_X   = 2'd0,
		REG_GOAL_Y   = 2'd1,
		REG_LIN_GAIN = 2'd2,
		REG_ANG_GAIN = 2'd3
	} reg_idx_t;

	function automatic logic signed [AW-1:0] atan_q30(input int i);
		logic signed [AW-1:0] r;
		begin
			case (i)
				0: r = 36'sh03243F6A8;
				1: r = 36'sh01DAC6705;
				2: r = 36'sh00FADBAFC;
				3: r = 36'sh007F56EA6;
				4: r = 36'sh003FEAB76;
				5: r = 36'sh001FFD55B;
				6: r = 36'sh000FFFAAA;
				7: r = 36'sh0007FFF55;
				8: r = 36'sh0003FFFEA;
				9: r = 36'sh0001FFFFD;
				10: r = 36'sh0000FFFFF;
				11: r = 36'sh00007FFFF;
				12: r = 36'sh00003FFFF;
				13: r = 36'sh00001FFFF;
				14: r = 36'sh00000FFFF;
				15: r = 36'sh000007FFF;
				16: r = 36'sh000003FFF;
				17: r = 36'sh000001FFF;
				18: r = 36'sh000000FFF;
				19: r = 36'sh0000007FF;
				20: r = 36'sh0000003FF;
				21: r = 36'sh0000001FF;
				22: r = 36'sh0000000FF;
				default: r = 36'sh00000007F;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/g2g_cordic_stage.sv =====
// One CORDIC micro-rotation step, vectoring or rotation mode, registered with stall.
`timescale 1ns / 1ps
`default_nettype none
module g2g_cordic_stage (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic [4:0]                       idx,
	input  wire logic                             vec_mode,
	input  wire logic signed [g2g_pkg::VW-1:0]    vx_in,
	input  wire logic signed [g2g_pkg::VW-1:0]    vy_in,
	input  wire logic signed [g2g_pkg::AW-1:0]    vz_in,
	input  wire logic signed [34:0]               rx_in,
	input  wire logic signed [34:0]               ry_in,
	input  wire logic signed [g2g_pkg::AW-1:0]    ra_in,
	output logic signed [g2g_pkg::VW-1:0]         vx_q,
	output logic signed [g2g_pkg::VW-1:0]         vy_q,
	output logic signed [g2g_pkg::AW-1:0]         vz_q,
	output logic signed [34:0]                    rx_q,
	output logic signed [34:0]                    ry_q,
	output logic signed [g2g_pkg::AW-1:0]         ra_q
);
	logic signed [g2g_pkg::AW-1:0] at;
	logic signed [g2g_pkg::VW-1:0] vxn, vyn;
	logic signed [g2g_pkg::AW-1:0] vzn, ran;
	logic signed [34:0] rxn, ryn;

	// only the selected mode steps; the other rotator passes its inputs through unchanged
	always_comb begin
		at = g2g_pkg::atan_q30(int'(idx));
		if (vy_in >= 0) begin
			vxn = vx_in + (vy_in >>> idx);
			vyn = vy_in - (vx_in >>> idx);
			vzn = vz_in + at;
		end else begin
			vxn = vx_in - (vy_in >>> idx);
			vyn = vy_in + (vx_in >>> idx);
			vzn = vz_in - at;
		end
		if (!vec_mode) begin
			vxn = vx_in;
			vyn = vy_in;
			vzn = vz_in;
		end
		if (ra_in >= 0) begin
			rxn = rx_in - (ry_in >>> idx);
			ryn = ry_in + (rx_in >>> idx);
			ran = ra_in - at;
		end else begin
			rxn = rx_in + (ry_in >>> idx);
			ryn = ry_in - (rx_in >>> idx);
			ran = ra_in + at;
		end
		if (vec_mode) begin
			rxn = rx_in;
			ryn = ry_in;
			ran = ra_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_q <= vxn;
			vy_q <= vyn;
			vz_q <= vzn;
			rx_q <= rxn;
			ry_q <= ryn;
			ra_q <= ran;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/go_to_goal_controller_core.sv =====
// Top level: pipelined go-to-goal controller with CORDIC bearing, distance and cosine.
//
//  channel   dir  handshake          payload
//  in        in   in_valid/in_stall   pos_x, pos_y, heading
//  out       out  out_valid/out_stall linear_speed, angular_rate
//  config    in   APB write/read      goal_x, goal_y, lin_gain, ang_gain
//
// One pose per cycle enters while the output is not stalled; each pose passes both CORDIC chains.
// Reset clears valid bits and loads register defaults.
// A stall at the output while out_valid is high freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module go_to_goal_controller_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] heading,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [14:0]             linear_speed,
	output logic signed [15:0]      angular_rate,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	localparam int N  = g2g_pkg::NSTG;
	localparam int VW = g2g_pkg::VW;
	localparam int AW = g2g_pkg::AW;
	localparam int G  = g2g_pkg::GUARD;
	// stages: s1 error, s2 prerotate, N vectoring, s3 gain+angle, s4 fold, N rotation,
	// s5 product, s6 scale, out
	localparam int NV = 2 * N + 7;

	logic signed [15:0] goal_x_q, goal_y_q;
	logic [15:0] lin_gain_q, ang_gain_q;
	logic en;
	logic [NV-1:0] vld_q;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q   <= '0;
			goal_y_q   <= '0;
			lin_gain_q <= 16'd6554;
			ang_gain_q <= 16'd16384;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (g2g_pkg::reg_idx_t'(paddr[3:2]))
				g2g_pkg::REG_GOAL_X:   goal_x_q   <= pwdata[15:0];
				g2g_pkg::REG_GOAL_Y:   goal_y_q   <= pwdata[15:0];
				g2g_pkg::REG_LIN_GAIN: lin_gain_q <= pwdata[15:0];
				g2g_pkg::REG_ANG_GAIN: ang_gain_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (g2g_pkg::reg_idx_t'(paddr[3:2]))
			g2g_pkg::REG_GOAL_X:   prdata = {{16{goal_x_q[15]}}, goal_x_q};
			g2g_pkg::REG_GOAL_Y:   prdata = {{16{goal_y_q[15]}}, goal_y_q};
			g2g_pkg::REG_LIN_GAIN: prdata = {16'd0, lin_gain_q};
			g2g_pkg::REG_ANG_GAIN: prdata = {16'd0, ang_gain_q};
			default:               prdata = '0;
		endcase
	end

	// global pipeline enable: the output register moves when not held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[NV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[NV-2:0], in_valid};
	end

	// s1: error vector
	logic signed [16:0] ex_s1, ey_s1;
	logic signed [15:0] hd_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1 <= 17'(goal_x_q) - 17'(pos_x);
			ey_s1 <= 17'(goal_y_q) - 17'(pos_y);
			hd_s1 <= heading;
		end
	end

	// s2: scale and quadrant prerotation
	logic signed [VW-1:0] vx_s2, vy_s2, sxv, syv;
	logic signed [AW-1:0] vz_s2;
	logic zero_s2;
	always_comb begin
		sxv = VW'(ex_s1) <<< G;
		syv = VW'(ey_s1) <<< G;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= (ex_s1 == 0) && (ey_s1 == 0);
			if (ex_s1 < 0) begin
				if (ey_s1 >= 0) begin
					vx_s2 <= syv; vy_s2 <= -sxv; vz_s2 <= g2g_pkg::HALF_PI_Q30;
				end else begin
					vx_s2 <= -syv; vy_s2 <= sxv; vz_s2 <= -g2g_pkg::HALF_PI_Q30;
				end
			end else begin
				vx_s2 <= sxv; vy_s2 <= syv; vz_s2 <= '0;
			end
		end
	end

	// side data carried along the vectoring chain
	logic signed [15:0] hd_d [0:N];
	logic zero_d [0:N];
	logic signed [VW-1:0] vx [0:N], vy [0:N];
	logic signed [AW-1:0] vz [0:N];
	logic signed [34:0] dmy_x [0:N], dmy_y [0:N];
	logic signed [AW-1:0] dmy_a [0:N];
	always_ff @(posedge clk) begin
		if (en) begin
			hd_d[0] <= hd_s1;
		end
	end
	assign zero_d[0] = zero_s2;
	assign vx[0] = vx_s2;
	assign vy[0] = vy_s2;
	assign vz[0] = vz_s2;
	assign dmy_x[0] = '0;
	assign dmy_y[0] = '0;
	assign dmy_a[0] = '0;

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_vec
			g2g_cordic_stage u_stg (
				.clk(clk), .en(en), .idx(5'(gi)), .vec_mode(1'b1),
				.vx_in(vx[gi]), .vy_in(vy[gi]), .vz_in(vz[gi]),
				.rx_in(dmy_x[gi]), .ry_in(dmy_y[gi]), .ra_in(dmy_a[gi]),
				.vx_q(vx[gi+1]), .vy_q(vy[gi+1]), .vz_q(vz[gi+1]),
				.rx_q(dmy_x[gi+1]), .ry_q(dmy_y[gi+1]), .ra_q(dmy_a[gi+1])
			);
			always_ff @(posedge clk) begin
				if (en) begin
					hd_d[gi+1]   <= hd_d[gi];
					zero_d[gi+1] <= zero_d[gi];
				end
			end
		end
	endgenerate

	// s3: magnitude gain, bearing error, turn rate product
	logic signed [AW-1:0] ang_c;
	logic signed [VW-1:0] mag_c;
	logic signed [16:0]   et12_c;
	logic signed [AW-1:0] ang_r;
	always_comb begin
		ang_c  = zero_d[N] ? '0 : vz[N];
		mag_c  = zero_d[N] ? '0 : vx[N];
		ang_r  = (ang_c + (AW'(1) <<< 17)) >>> 18;
		et12_c = 17'(ang_r) - 17'(hd_d[N]);
	end
	logic signed [VW+21:0] magk_s3;
	logic signed [AW-1:0]  et30_s3;
	logic signed [34:0]    rate_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			magk_s3 <= (VW+22)'(mag_c) * (VW+22)'(g2g_pkg::K_Q20);
			et30_s3 <= ang_c - (AW'(hd_d[N]) <<< 18);
			rate_s3 <= 35'(signed'({1'b0, ang_gain_q})) * 35'(et12_c);
		end
	end

	// s4: angle reduction into [0, pi/2] and distance scaling
	logic signed [AW-1:0] a_r;
	logic neg_c;
	always_comb begin
		a_r = et30_s3;
		for (int k = 0; k < 3; k++) begin
			if (a_r > g2g_pkg::PI_Q30) a_r = a_r - g2g_pkg::TWO_PI_Q30;
			else if (a_r < -g2g_pkg::PI_Q30) a_r = a_r + g2g_pkg::TWO_PI_Q30;
		end
		if (a_r < 0) a_r = -a_r;
		neg_c = 1'b0;
		if (a_r > g2g_pkg::HALF_PI_Q30) begin
			a_r = g2g_pkg::PI_Q30 - a_r;
			neg_c = 1'b1;
		end
	end
	logic signed [VW+1:0] dist_s4;
	logic neg_s4;
	logic signed [AW-1:0] a_s4;
	logic signed [34:0] rate_s4;
	logic signed [VW+21:0] dsh;
	always_comb dsh = (magk_s3 >>> 20) >>> (G - 4);
	always_ff @(posedge clk) begin
		if (en) begin
			dist_s4 <= (VW+2)'(dsh);
			neg_s4  <= neg_c;
			a_s4    <= a_r;
			rate_s4 <= rate_s3;
		end
	end

	// rotation chain for the cosine
	logic signed [34:0] rx [0:N], ry [0:N];
	logic signed [AW-1:0] ra [0:N];
	logic signed [VW-1:0] ux [0:N], uy [0:N];
	logic signed [AW-1:0] uz [0:N];
	logic signed [VW+1:0] dist_d [0:N];
	logic neg_d [0:N];
	logic signed [34:0] rate_d [0:N];
	assign rx[0] = 35'(g2g_pkg::K_Q30);
	assign ry[0] = '0;
	assign ra[0] = a_s4;
	assign ux[0] = '0;
	assign uy[0] = '0;
	assign uz[0] = '0;
	assign dist_d[0] = dist_s4;
	assign neg_d[0]  = neg_s4;
	assign rate_d[0] = rate_s4;
	generate
		for (gi = 0; gi < N; gi++) begin : g_rot
			g2g_cordic_stage u_stg (
				.clk(clk), .en(en), .idx(5'(gi)), .vec_mode(1'b0),
				.vx_in(ux[gi]), .vy_in(uy[gi]), .vz_in(uz[gi]),
				.rx_in(rx[gi]), .ry_in(ry[gi]), .ra_in(ra[gi]),
				.vx_q(ux[gi+1]), .vy_q(uy[gi+1]), .vz_q(uz[gi+1]),
				.rx_q(rx[gi+1]), .ry_q(ry[gi+1]), .ra_q(ra[gi+1])
			);
			always_ff @(posedge clk) begin
				if (en) begin
					dist_d[gi+1] <= dist_d[gi];
					neg_d[gi+1]  <= neg_d[gi];
					rate_d[gi+1] <= rate_d[gi];
				end
			end
		end
	endgenerate

	// s5: projection product
	logic signed [34:0] c30;
	always_comb c30 = neg_d[N] ? -rx[N] : rx[N];
	logic signed [VW+36:0] prod_s5;
	logic signed [34:0] rate_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= (VW+37)'(dist_d[N]) * (VW+37)'(c30);
			rate_s5 <= rate_d[N];
		end
	end

	// s6: round projection, round and saturate turn rate
	logic signed [VW+36:0] proj_w;
	logic signed [34:0] rr;
	logic signed [15:0] rate_sat;
	always_comb begin
		proj_w = (prod_s5 + ((VW+37)'(1) <<< 33)) >>> 34;
		rr = (rate_s5 + 35'sd8192) >>> 14;
		if (rr > 35'sd32767) rate_sat = 16'sh7FFF;
		else if (rr < -35'sd32768) rate_sat = 16'sh8000;
		else rate_sat = rr[15:0];
	end
	logic signed [VW+1:0] proj_s6;
	logic signed [15:0] rate_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			proj_s6 <= (VW+2)'(proj_w);
			rate_s6 <= rate_sat;
		end
	end

	// output register: speed gain, rounding and clamp
	logic signed [VW+19:0] sp_w;
	logic [14:0] sp_c;
	always_comb begin
		sp_w = ((VW+20)'(signed'({1'b0, lin_gain_q})) * (VW+20)'(proj_s6)
			+ (VW+20)'(16384)) >>> 15;
		if (proj_s6 <= 0) sp_c = '0;
		else if (sp_w > (VW+20)'(32767)) sp_c = 15'h7FFF;
		else sp_c = sp_w[14:0];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			linear_speed <= sp_c;
			angular_rate <= rate_s6;
		end
	end
endmodule
`default_nettype wire
